// File: hdl/iracl_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 range ACL package
// Shared types and helpers for the access list matcher and its rule cells.
// ----------------------------------------------------------------------------
package iracl_pkg;

  localparam int ADDR_W  = 32;
  localparam int IDX_W   = 4;
  localparam int PLEN_W  = 6;
  localparam int COUNT_W = 5;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] range_lo;
    logic [ADDR_W-1:0] range_hi;
    logic              deny;
  } rule_wr_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic              deny;
    logic [IDX_W-1:0]  idx;
    logic              last_deny;
  } lookup_t;

  // Prefix lengths above the address width saturate to a single address.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] mask;
    if (plen > PLEN_W'(ADDR_W)) begin
      mask = '1;
    end else begin
      mask = ~({ADDR_W{1'b1}} >> plen);
    end
    return mask;
  endfunction

endpackage

// File: hdl/iracl_cell.sv
// ----------------------------------------------------------------------------
// IPv4 range ACL rule cell
// Holds one rule and checks the lookup that passes through it each cycle.
// ----------------------------------------------------------------------------
module iracl_cell #(
  parameter int MAX_RULES  = 16,
  parameter int CELL_INDEX = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  iracl_pkg::rule_wr_t              wr,
  input  logic [iracl_pkg::COUNT_W-1:0]    rule_count,
  input  iracl_pkg::lookup_t               tok_in,
  output iracl_pkg::lookup_t               tok_out
);

  logic [iracl_pkg::ADDR_W-1:0] range_lo;
  logic [iracl_pkg::ADDR_W-1:0] range_hi;
  logic                         deny_flag;
  iracl_pkg::lookup_t           tok_next;
  logic                         active;
  logic                         is_last;
  logic                         hit;

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.index) == CELL_INDEX)) begin
      range_lo  <= wr.range_lo;
      range_hi  <= wr.range_hi;
      deny_flag <= wr.deny;
    end
  end

  assign active  = 32'(rule_count) > CELL_INDEX;
  assign is_last = (32'(rule_count) == CELL_INDEX + 1) ||
                   ((CELL_INDEX == MAX_RULES - 1) && (32'(rule_count) >= MAX_RULES));
  assign hit     = tok_in.valid && active && !tok_in.found &&
                   (tok_in.addr >= range_lo) && (tok_in.addr <= range_hi);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.deny  = deny_flag;
      tok_next.idx   = iracl_pkg::IDX_W'(CELL_INDEX);
    end
    if (is_last) begin
      tok_next.last_deny = deny_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// File: hdl/ipv4_range_acl_matcher.sv
// ----------------------------------------------------------------------------
// IPv4 range access list matcher
// First-match access list over CIDR rules, built as a chain of rule cells.
// ----------------------------------------------------------------------------
// A rule write is taken without raising busy, so the block stays ready. A
// lookup walks the chain of MAX_RULES rule cells, one cell per cycle, and its
// result appears at the end of the chain with done high for a single cycle;
// busy is raised by the transfer and drops when the result is shown, so a new
// lookup cannot be taken while one is still in the chain. The next transfer
// may be taken in the cycle the result is shown. Results cannot be held off by the receiver.
module ipv4_range_acl_matcher #(
  parameter int MAX_RULES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [iracl_pkg::IDX_W-1:0]       rule_index,
  input  logic [iracl_pkg::ADDR_W-1:0]      rule_base,
  input  logic [iracl_pkg::PLEN_W-1:0]      prefix_length,
  input  logic                              rule_denies,
  input  logic [iracl_pkg::ADDR_W-1:0]      client_address,
  input  logic                              cfg_we,
  input  logic [iracl_pkg::COUNT_W-1:0]     cfg_wdata,
  output logic                              done,
  output logic                              denied,
  output logic                              by_default,
  output logic [iracl_pkg::IDX_W-1:0]       matched_rule
);

  localparam int STEP_W = $clog2(MAX_RULES + 1);

  logic [iracl_pkg::COUNT_W-1:0] rule_count;
  logic [STEP_W-1:0]             steps;
  logic                          accept;
  logic                          accept_lookup;
  logic [iracl_pkg::ADDR_W-1:0]  mask;
  iracl_pkg::rule_wr_t           wr;
  iracl_pkg::lookup_t            tok [MAX_RULES+1];
  iracl_pkg::lookup_t            tail;

  assign accept        = start && !busy;
  assign accept_lookup = accept && (operation == iracl_pkg::OP_LOOKUP);
  assign busy          = steps != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (cfg_we) begin
      rule_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (accept_lookup) begin
      steps <= STEP_W'(MAX_RULES - 1);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_comb begin
    mask        = iracl_pkg::prefix_mask(prefix_length);
    wr.en       = accept && (operation == iracl_pkg::OP_WRITE);
    wr.index    = rule_index;
    wr.range_lo = rule_base & mask;
    wr.range_hi = (rule_base & mask) | ~mask;
    wr.deny     = rule_denies;
  end

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = accept_lookup;
    tok[0].addr      = client_address;
  end

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    iracl_cell #(
      .MAX_RULES  (MAX_RULES),
      .CELL_INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr         (wr),
      .rule_count (rule_count),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  assign tail         = tok[MAX_RULES];
  assign done         = tail.valid;
  assign by_default   = !tail.found;
  assign matched_rule = tail.idx;
  assign denied       = tail.found ? tail.deny :
                        ((rule_count == '0) ? 1'b0 : !tail.last_deny);

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    accept_lookup |=> (busy == (MAX_RULES > 1)))
    else $error("Lookup transfer did not hold the block busy.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result shown while the chain was still busy.");

  a_default_index: assert property (@(posedge clk) disable iff (rst)
    (done && by_default) |-> (matched_rule == '0))
    else $error("Default verdict carried a nonzero rule index.");

  a_empty_allows: assert property (@(posedge clk) disable iff (rst)
    (done && (rule_count == '0)) |-> (by_default && !denied))
    else $error("Empty rule list did not allow the address.");

endmodule
